[sv/dnle_pkg.sv]
// dnle_pkg: shared constants, types and state codes for the domain name label encoder
// depends on nothing; imported by every module of the encoder but dnle_ram
package dnle_pkg;

   localparam int MAX_LABEL  = 62;
   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = $clog2(MAX_LABEL + 1);
   localparam int ADDR_W     = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;
   localparam logic [CHAR_W-1:0] NUL_BYTE = 8'h00;

   // one queued job: emit a label and/or the terminator
   typedef struct packed {
      logic               do_flush;
      logic               do_term;
      logic [COUNT_W-1:0] count;
      logic               ovf;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LEN,
      BK_READ,
      BK_DATA,
      BK_TERM
   } back_state_type;

endpackage

[sv/dnle_ram.sv]
// dnle_ram: generic single write port, single read port ram with registered read
// depends on nothing
module dnle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 62,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/dnle_front.sv]
// dnle_front: accepts characters, fills the label ram and queues emit jobs
// depends on dnle_pkg
module dnle_front
   import dnle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CHAR_W-1:0] in_char,
   input  logic              in_end,
   input  logic              queue_full,
   input  logic              flush_pending,
   output logic              push,
   output cmd_type           push_cmd,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [CHAR_W-1:0] ram_wr_data
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               accept, is_dot, store, drop;
   logic [COUNT_W-1:0] count_plus;

   // label ram is only written while no label is waiting to be read out
   assign in_ready = !queue_full && !flush_pending;
   assign accept   = in_valid && in_ready;
   assign is_dot   = (in_char == DOT_CHAR);
   assign store    = !is_dot && (count_ff < COUNT_W'(MAX_LABEL));
   assign drop     = !is_dot && !store;
   assign count_plus = store ? (count_ff + 1'b1) : count_ff;

   assign ram_wr_en   = accept && store;
   assign ram_wr_addr = count_ff[ADDR_W-1:0];
   assign ram_wr_data = in_char;

   always_comb begin
      push              = accept && (is_dot || in_end);
      push_cmd.do_flush = is_dot || in_end;
      push_cmd.do_term  = in_end;
      push_cmd.count    = is_dot ? count_ff : count_plus;
      push_cmd.ovf      = ovf_ff || drop;
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         count_in = (is_dot || in_end) ? '0 : count_plus;
         ovf_in   = in_end ? 1'b0 : (ovf_ff || drop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

[sv/dnle_cmd_fifo.sv]
// dnle_cmd_fifo: short job queue between the front and the back end
// depends on dnle_pkg
module dnle_cmd_fifo
   import dnle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty,
   output logic    full,
   output logic    flush_held
);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;

   assign full    = valid_ff[wr_ptr_ff];
   assign empty   = !valid_ff[rd_ptr_ff];
   assign pop_cmd = mem_ff[rd_ptr_ff];

   // any queued job that will read the label ram
   always_comb begin
      flush_held = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         flush_held = flush_held || (valid_ff[i] && mem_ff[i].do_flush);
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (pop && !empty) begin
         valid_in[rd_ptr_ff] = 1'b0;
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !full) begin
         valid_in[wr_ptr_ff] = 1'b1;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

[sv/dnle_back.sv]
// dnle_back: runs queued jobs, reads the label ram and drives the output register
// depends on dnle_pkg
module dnle_back
   import dnle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  cmd_type           queue_cmd,
   output logic              queue_pop,
   output logic              label_busy,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [CHAR_W-1:0] ram_rd_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CHAR_W-1:0] out_byte,
   output logic              out_last,
   output logic              out_ovf
);

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic               out_ovf_ff, out_ovf_in;

   logic               slot_free;
   logic               load;
   logic [COUNT_W-1:0] idx_plus;

   assign slot_free = !out_valid_ff || out_ready;
   assign idx_plus  = idx_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               state_in = queue_cmd.do_flush ? BK_LEN : BK_TERM;
            end
         end
         BK_LEN: begin
            if (slot_free) begin
               if (cmd_ff.count != '0) begin
                  state_in = BK_READ;
               end else begin
                  state_in = cmd_ff.do_term ? BK_TERM : BK_IDLE;
               end
            end
         end
         BK_READ: begin
            state_in = BK_DATA;
         end
         BK_DATA: begin
            if (slot_free) begin
               if (idx_plus != cmd_ff.count) begin
                  state_in = BK_READ;
               end else begin
                  state_in = cmd_ff.do_term ? BK_TERM : BK_IDLE;
               end
            end
         end
         BK_TERM: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      queue_pop   = 1'b0;
      ram_rd_en   = 1'b0;
      load        = 1'b0;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_ovf_in  = out_ovf_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               cmd_in    = queue_cmd;
            end
         end
         BK_LEN: begin
            if (slot_free) begin
               load        = 1'b1;
               out_byte_in = CHAR_W'(cmd_ff.count);
               out_last_in = 1'b0;
               out_ovf_in  = 1'b0;
               idx_in      = '0;
            end
         end
         BK_READ: begin
            ram_rd_en = 1'b1;
         end
         BK_DATA: begin
            if (slot_free) begin
               load        = 1'b1;
               out_byte_in = ram_rd_data;
               out_last_in = 1'b0;
               out_ovf_in  = 1'b0;
               idx_in      = idx_plus;
            end
         end
         BK_TERM: begin
            if (slot_free) begin
               load        = 1'b1;
               out_byte_in = NUL_BYTE;
               out_last_in = 1'b1;
               out_ovf_in  = cmd_ff.ovf;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign ram_rd_addr = idx_ff[ADDR_W-1:0];
   assign label_busy  = (state_ff == BK_LEN) || (state_ff == BK_READ) || (state_ff == BK_DATA);

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;
   assign out_ovf   = out_ovf_ff;

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[sv/domain_name_label_encoder.sv]
// domain_name_label_encoder: dotted name in, dns wire-format name out, one byte per beat
// a closed label passes through the job queue and the back end's idle and length states
// to the output register; plain characters go in one per cycle while no label is queued
// or draining (ram read then output load per byte); new characters wait meanwhile
// reset: synchronous, active high; clears counters, job queue and sequencer, label ram
// is not cleared (only bytes written for the open label are ever read)
module domain_name_label_encoder
   import dnle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel: one character per beat
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] name_char
   input  logic       req_tlast,   // end_of_name
   // response channel: one wire-format byte per beat
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] wire_byte
   output logic       rsp_tlast,   // last_byte, set on the zero terminator
   output logic       rsp_tuser    // [0] label_overflow, valid on the terminator
);

   // front to queue
   logic              push;
   cmd_type           push_cmd;
   logic              queue_full;
   logic              queue_empty;
   logic              flush_held;
   // queue to back end
   cmd_type           pop_cmd;
   logic              pop;
   logic              label_busy;
   // label ram
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CHAR_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CHAR_W-1:0] ram_rd_data;

   // front stalls while any label sits in the queue or is being read out,
   // so the label ram never holds two labels at once
   dnle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_char       (req_tdata),
      .in_end        (req_tlast),
      .queue_full    (queue_full),
      .flush_pending (flush_held || label_busy),
      .push          (push),
      .push_cmd      (push_cmd),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data)
   );

   // short job queue: a dot or final character becomes one job
   dnle_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .pop_cmd    (pop_cmd),
      .empty      (queue_empty),
      .full       (queue_full),
      .flush_held (flush_held)
   );

   // label bytes of the open label
   dnle_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_LABEL)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // back end: length byte, label bytes, terminator, through an output register
   dnle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_cmd   (pop_cmd),
      .queue_pop   (pop),
      .label_busy  (label_busy),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast),
      .out_ovf     (rsp_tuser)
   );

endmodule

[sim/dnle_checker.sv]
// dnle_checker: watches the character and wire-byte channels of the label encoder,
// predicts the wire-format bytes of each name and compares them beat by beat
// depends on dnle_pkg for the label capacity and the dot and terminator codes
module dnle_checker
   import dnle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [CHAR_W-1:0] req_tdata,
   input  logic              req_tlast,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [CHAR_W-1:0] rsp_tdata,
   input  logic              rsp_tlast,
   input  logic              rsp_tuser,
   output int                mismatch_count,
   output int                bytes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CHAR_W-1:0] wire_byte;
      logic              last_byte;
      logic              label_overflow;
   } wire_beat_type;

   wire_beat_type      wire_bytes_due[$];
   logic [CHAR_W-1:0]  open_label [MAX_LABEL];
   logic [COUNT_W-1:0] open_count;
   logic               name_dropped;

   task automatic queue_byte(input logic [CHAR_W-1:0] b, input logic is_last,
                             input logic ovf);
      wire_beat_type beat;
      beat.wire_byte      = b;
      beat.last_byte      = is_last;
      beat.label_overflow = ovf;
      wire_bytes_due.push_back(beat);
   endtask

   // length prefix, then the held bytes in arrival order
   task automatic close_label();
      queue_byte(CHAR_W'(open_count), 1'b0, 1'b0);
      for (int k = 0; k < int'(open_count); k++)
         queue_byte(open_label[k], 1'b0, 1'b0);
      open_count = '0;
   endtask

   task automatic encode_char(input logic [CHAR_W-1:0] ch, input logic fin);
      if (ch == DOT_CHAR) begin
         close_label();
      end else begin
         if (int'(open_count) < MAX_LABEL) begin
            open_label[open_count] = ch;
            open_count = open_count + 1'b1;
         end else begin
            name_dropped = 1'b1;
         end
         if (fin)
            close_label();
      end
      if (fin) begin
         queue_byte(NUL_BYTE, 1'b1, name_dropped);
         open_count   = '0;
         name_dropped = 1'b0;
      end
   endtask

   task automatic match_beat();
      wire_beat_type want;
      if (wire_bytes_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("[%0t] unexpected wire byte %02h last %b ovf %b", $time,
                     rsp_tdata, rsp_tlast, rsp_tuser);
      end else begin
         want = wire_bytes_due.pop_front();
         if (rsp_tdata !== want.wire_byte || rsp_tlast !== want.last_byte ||
             rsp_tuser !== want.label_overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] wire byte: expected %02h/%b/%b got %02h/%b/%b", $time,
                        want.wire_byte, want.last_byte, want.label_overflow,
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wire_bytes_due.delete();
         open_count     = '0;
         name_dropped   = 1'b0;
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready)
            encode_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            match_beat();
      end
      bytes_outstanding = wire_bytes_due.size();
   end

endmodule

[sim/tb_domain_name_label_encoder.sv]
// tb_domain_name_label_encoder: drives dotted names into the label encoder with bursty
// character beats and a stalling byte sink, and gives the verdict from the checker
// depends on dnle_pkg, domain_name_label_encoder and dnle_checker
module tb_domain_name_label_encoder;
   timeunit 1ns;
   timeprecision 1ps;
   import dnle_pkg::*;

   localparam int ITEM_TARGET   = 210;
   // longest quiet stretch of a correct run is a sink stall plus the encoder's latency
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 16;

   // sink behaviour, chosen anew at random each time its phase count runs out
   typedef enum logic [1:0] {
      RX_FREE,    // always ready
      RX_COIN,    // ready half the time
      RX_SPARSE,  // ready one cycle in four
      RX_LIGHT    // an occasional stall
   } rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   int          mismatch_count;
   int          bytes_outstanding;

   rx_mode_type rx_mode     = RX_FREE;
   int          rx_phase    = 0;
   int          quiet_cycles = 0;
   int          burst_left  = 0;
   int          items_sent  = 0;
   logic [7:0]  name_text[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   domain_name_label_encoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] name_char
      .req_tlast  (req_tlast),   // end_of_name
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] wire_byte
      .rsp_tlast  (rsp_tlast),   // last_byte
      .rsp_tuser  (rsp_tuser)    // [0] label_overflow
   );

   dnle_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .rsp_tuser         (rsp_tuser),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding)
   );

   // byte sink: stall pattern of its own, independent of the sender
   always @(negedge clock) begin
      if (rx_phase == 0) begin
         rx_mode  <= rx_mode_type'($urandom_range(0, 3));
         rx_phase <= $urandom_range(8, 40);
      end else begin
         rx_phase <= rx_phase - 1;
      end
      case (rx_mode)
         RX_FREE:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= ($urandom_range(0, 1) == 0);
         RX_SPARSE: rsp_tready <= (rx_phase % 4 == 0);
         default:   rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // watchdog: any accepted beat on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one character beat; called and returns at a falling edge
   task automatic send_char(input logic [7:0] ch, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         // a quarter of the bursts follow on with no gap at all
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // sends the text built up so far, end flag on its final character
   task automatic send_name();
      for (int i = 0; i < name_text.size(); i++)
         send_char(name_text[i], i == name_text.size() - 1);
      name_text.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         name_text.push_back(s[i]);
   endtask

   function automatic logic [7:0] label_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == DOT_CHAR)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // sender holds off until every predicted byte has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (bytes_outstanding != 0)
         @(negedge clock);
   endtask

   // well-formed name: a few labels, the odd empty or oversize one, maybe a trailing dot
   task automatic random_name();
      int labels;
      int len;
      labels = $urandom_range(1, 4);
      for (int l = 0; l < labels; l++) begin
         if (l > 0)
            name_text.push_back(DOT_CHAR);
         case ($urandom_range(0, 31))
            0:       len = 0;
            1:       len = $urandom_range(MAX_LABEL - 3, MAX_LABEL + 4);
            default: len = $urandom_range(1, 10);
         endcase
         repeat (len)
            name_text.push_back(label_char());
      end
      if ($urandom_range(0, 3) == 0 || name_text.size() == 0)
         name_text.push_back(DOT_CHAR);
      send_name();
   endtask

   // noise: dots and characters at random, end flag anywhere or nowhere
   task automatic noise_run();
      int n;
      n = $urandom_range(1, 8);
      repeat (n)
         send_char(($urandom_range(0, 3) == 0) ? DOT_CHAR : 8'($urandom_range(0, 255)),
                   $urandom_range(0, 5) == 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed names
      add_text("a");                 // single character closed by the end flag
      send_name();
      add_text(".");                 // lone dot as the whole name
      send_name();
      add_text("ab.c");              // two labels, no trailing dot
      send_name();
      add_text("x.");                // trailing dot ends the name
      send_name();
      add_text("..");                // two empty labels
      send_name();
      add_text(".q");                // empty leading label
      send_name();
      name_text.push_back(8'h00);    // zero and all-ones characters are plain bytes
      name_text.push_back(8'hFF);
      name_text.push_back(DOT_CHAR);
      name_text.push_back(8'h7F);
      name_text.push_back(8'h80);
      send_name();
      wait_drained();

      // a label filled exactly, then one that spills over with a label after it
      repeat (MAX_LABEL)
         name_text.push_back(label_char());
      send_name();
      repeat (MAX_LABEL + 2)
         name_text.push_back(label_char());
      add_text(".z");
      send_name();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 4) == 0)
            noise_run();
         else
            random_name();
         if ($urandom_range(0, 9) == 0)
            wait_drained();
      end

      req_tvalid <= 1'b0;
      while (bytes_outstanding != 0)
         @(negedge clock);
      // let any stray byte show up before the verdict
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && bytes_outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
